@@ rtl/satl_pkg.sv @@
// Shared types, constants and helpers for the set-associative tag lookup unit.
// No dependencies; used by every module of the block.
package satl_pkg;

    localparam int DEF_TOTAL_BLOCKS = 2048;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int OFS_W      = 3;
    localparam int WL_W       = 4;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int LFSR_W     = 16;
    localparam int SHIFT_W    = 5;

    localparam logic [OFS_W-1:0]  OFFSET_BITS_RST = 3'd4;
    localparam logic [WL_W-1:0]   WAYS_LOG2_RST   = 4'd3;
    localparam logic [LFSR_W-1:0] LFSR_SEED       = 16'hACE1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 1'b0,
        CFG_WAYS_LOG2   = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADIV,
        ST_AWAIT,
        ST_SCAN,
        ST_LFSR,
        ST_VDIV,
        ST_VWAIT,
        ST_WRITE,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic div_addr;
        logic div_vic;
        logic take_addr;
        logic scan;
        logic lfsr_adv;
        logic take_vic;
        logic wr;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
        logic scan_done;
        logic hit;
        logic free;
    } t_sts;

    // Fibonacci LFSR, taps 16,14,13,11, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

endpackage

@@ rtl/set_assoc_cache_tag_lookup_unit.sv @@
// Top level of the set-associative tag lookup unit with random replacement.
// Depends on satl_pkg, satl_ctrl, satl_dp (and satl_div below it).
//
//   port group      dir   handshake                 content
//   item in         in    start high, busy low      i_address
//   result          out   o_valid, one cycle        o_hit, o_hit_total, o_miss_total
//   configuration   in    i_cfg_we                  i_cfg_index, i_cfg_data
//
// An item on a hit goes straight to the result; a miss fills a free way if the
// scan found one, else a random victim way. The way scan reads one way per cycle
// from the single-port tag memory; the last read is registered and then compared.
// With a TOTAL_BLOCKS that is not a power of two, each division by an uneven
// set or way count runs in the shared bit-serial divider.
// After reset a clearing pass over all TOTAL_BLOCKS tag entries keeps busy high.
// The result strobe cannot be stalled; busy is low in the strobe cycle.
module set_assoc_cache_tag_lookup_unit #(
    parameter int TOTAL_BLOCKS = satl_pkg::DEF_TOTAL_BLOCKS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [satl_pkg::ADDR_W-1:0]        i_address,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic [satl_pkg::CNT_W-1:0]         o_hit_total,
    output logic [satl_pkg::CNT_W-1:0]         o_miss_total,
    input  logic                               i_cfg_we,
    input  logic [satl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [satl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    satl_pkg::t_cmd cmd;
    satl_pkg::t_sts sts;

    satl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    satl_dp #(
        .TOTAL_BLOCKS (TOTAL_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_address    (i_address),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_total + o_miss_total) ==
                    ($past(o_hit_total) + $past(o_miss_total) + 32'd1))
        else $error("counters did not advance by one item");

    a_hit_keeps_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> o_miss_total == $past(o_miss_total))
        else $error("miss count moved on a hit");

endmodule

@@ rtl/satl_div.sv @@
// Shared divider: restoring, one quotient bit per cycle, with a shift-and-mask
// path for power-of-two divisors that registers its result straight from the inputs. Depends on satl_pkg.
module satl_div #(
    parameter int VW = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_fast,
    input  logic [satl_pkg::SHIFT_W-1:0]     i_shift,
    input  logic [satl_pkg::ADDR_W-1:0]      i_dividend,
    input  logic [VW-1:0]                    i_divisor,
    output logic [satl_pkg::ADDR_W-1:0]      o_quo,
    output logic [VW-1:0]                    o_rem,
    output logic                             o_busy
);

    localparam int DW = satl_pkg::ADDR_W;
    localparam int SW = $clog2(DW);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [SW-1:0] r_cnt;
    logic          r_busy;

    logic [VW:0]   trial;
    logic          ge;
    logic [VW:0]   diff;
    logic [DW-1:0] fast_mask;

    assign trial     = {r_rem, r_quo[DW-1]};
    assign ge        = trial >= {1'b0, i_divisor};
    assign diff      = trial - {1'b0, i_divisor};
    assign fast_mask = (DW'(1) << i_shift) - DW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !i_fast;
            r_cnt  <= SW'(DW - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - SW'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_fast) begin
                r_quo <= i_dividend >> i_shift;
                r_rem <= VW'(i_dividend & fast_mask);
            end else begin
                r_quo <= i_dividend;
                r_rem <= '0;
            end
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_busy = r_busy;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_fast) |=> (r_busy && r_cnt == SW'(DW - 1)))
        else $error("divider did not load its step count");

    a_done_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> !r_busy)
        else $error("divider ran past its last step");

endmodule

@@ rtl/satl_dp.sv @@
// Datapath: configuration, tag memory with valid bits, way scan, victim
// selection, counters and result registers. Depends on satl_pkg, satl_div.
module satl_dp #(
    parameter int TOTAL_BLOCKS = satl_pkg::DEF_TOTAL_BLOCKS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [satl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [satl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [satl_pkg::ADDR_W-1:0]        i_address,
    input  satl_pkg::t_cmd                     i_cmd,
    output satl_pkg::t_sts                     o_sts,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic [satl_pkg::CNT_W-1:0]         o_hit_total,
    output logic [satl_pkg::CNT_W-1:0]         o_miss_total
);

    localparam int CW        = $clog2(TOTAL_BLOCKS + 1);
    localparam int AW        = $clog2(TOTAL_BLOCKS);
    localparam int LOG_FLOOR = CW - 1;
    localparam bit IS_POW2   = (TOTAL_BLOCKS & (TOTAL_BLOCKS - 1)) == 0;
    localparam int TW        = satl_pkg::TAG_W;
    localparam int SHW       = satl_pkg::SHIFT_W;

    logic [TW:0] mem [TOTAL_BLOCKS];

    logic [satl_pkg::OFS_W-1:0]  r_offset;
    logic [satl_pkg::WL_W-1:0]   r_wl;
    logic [satl_pkg::LFSR_W-1:0] r_lfsr;
    logic [satl_pkg::CNT_W-1:0]  r_hits;
    logic [satl_pkg::CNT_W-1:0]  r_misses;
    logic                        r_valid;
    logic [AW-1:0]               r_clr;
    logic                        r_rd_vld;
    logic [CW-1:0]               r_idx;
    logic                        r_hit;
    logic                        r_free;

    logic [satl_pkg::ADDR_W-1:0] r_addr;
    logic [TW-1:0]               r_tag;
    logic [AW-1:0]               r_base;
    logic [AW-1:0]               r_rd_line;
    logic [TW:0]                 r_rd;
    logic [AW-1:0]               r_fill;

    logic                        sat;
    logic [CW-1:0]               ways_cnt;
    logic [CW-1:0]               sets;
    logic [SHW-1:0]              sets_sh;
    logic [SHW-1:0]              ways_sh;
    logic [satl_pkg::ADDR_W-1:0] blk;
    logic                        issue;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [TW:0]                 wr_data;
    logic                        div_start;
    logic                        div_fast;
    logic [SHW-1:0]              div_shift;
    logic [satl_pkg::ADDR_W-1:0] div_dividend;
    logic [CW-1:0]               div_divisor;
    logic [satl_pkg::ADDR_W-1:0] div_quo;
    logic [CW-1:0]               div_rem;
    logic                        div_busy;

    // geometry from the configuration
    assign sat      = {1'b0, r_wl} > SHW'(LOG_FLOOR);
    assign ways_cnt = sat ? CW'(TOTAL_BLOCKS) : (CW'(1) << r_wl);
    assign sets     = sat ? CW'(1) : (CW'(TOTAL_BLOCKS) >> r_wl);
    assign sets_sh  = sat ? '0 : (SHW'(LOG_FLOOR) - {1'b0, r_wl});
    assign ways_sh  = sat ? SHW'(LOG_FLOOR) : {1'b0, r_wl};
    assign blk      = r_addr >> r_offset;

    assign div_start    = i_cmd.div_addr || i_cmd.div_vic;
    assign div_dividend = i_cmd.div_vic ? satl_pkg::ADDR_W'(r_lfsr) : blk;
    assign div_divisor  = i_cmd.div_vic ? ways_cnt : sets;
    assign div_fast     = i_cmd.div_vic ? (!sat || IS_POW2) : (sat || IS_POW2);
    assign div_shift    = i_cmd.div_vic ? ways_sh : sets_sh;

    satl_div #(
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_fast     (div_fast),
        .i_shift    (div_shift),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_busy     (div_busy)
    );

    assign issue   = i_cmd.scan && (r_idx != ways_cnt);
    assign rd_addr = r_base + AW'(r_idx);
    assign wr_addr = i_cmd.clr ? r_clr : r_fill;
    assign wr_data = i_cmd.clr ? '0 : {1'b1, r_tag};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.wr) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= satl_pkg::OFFSET_BITS_RST;
            r_wl     <= satl_pkg::WAYS_LOG2_RST;
            r_lfsr   <= satl_pkg::LFSR_SEED;
            r_hits   <= '0;
            r_misses <= '0;
            r_valid  <= 1'b0;
            r_clr    <= '0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == satl_pkg::CFG_OFFSET_BITS) begin
                    r_offset <= i_cfg_data[satl_pkg::OFS_W-1:0];
                end else begin
                    r_wl <= i_cfg_data[satl_pkg::WL_W-1:0];
                end
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.lfsr_adv) begin
                r_lfsr <= satl_pkg::lfsr_next(r_lfsr);
            end
            if (i_cmd.fin) begin
                if (r_hit) begin
                    r_hits <= r_hits + satl_pkg::CNT_W'(1);
                end else begin
                    r_misses <= r_misses + satl_pkg::CNT_W'(1);
                end
            end
            r_valid  <= i_cmd.fin;
            r_rd_vld <= issue;
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    if (r_rd[TW] && r_rd[TW-1:0] == r_tag) begin
                        r_hit <= 1'b1;
                    end else if (!r_rd[TW] && !r_free) begin
                        r_free <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_address;
        end
        if (i_cmd.take_addr) begin
            r_tag  <= div_quo;
            r_base <= AW'(div_rem << r_wl);
        end
        if (issue) begin
            r_rd_line <= rd_addr;
        end
        if (i_cmd.take_vic) begin
            r_fill <= r_base + AW'(div_rem);
        end else if (r_rd_vld && !r_rd[TW] && !r_free) begin
            r_fill <= r_rd_line;
        end
    end

    assign o_sts.clr_last  = r_clr == AW'(TOTAL_BLOCKS - 1);
    assign o_sts.div_busy  = div_busy;
    assign o_sts.scan_done = (r_idx == ways_cnt) && !r_rd_vld;
    assign o_sts.hit       = r_hit;
    assign o_sts.free      = r_free;

    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_hit_total  = r_hits;
    assign o_miss_total = r_misses;

endmodule

@@ rtl/satl_ctrl.sv @@
// Controller: sequences clear pass, set/tag split, way scan, victim pick,
// fill and result for one item at a time. Depends on satl_pkg.
module satl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  satl_pkg::t_sts    i_sts,
    output satl_pkg::t_cmd    o_cmd,
    output logic              busy
);

    satl_pkg::t_state r_state;
    satl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= satl_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            satl_pkg::ST_CLEAR: if (i_sts.clr_last) n_state = satl_pkg::ST_IDLE;
            satl_pkg::ST_IDLE:  if (start) n_state = satl_pkg::ST_ADIV;
            satl_pkg::ST_ADIV:  n_state = satl_pkg::ST_AWAIT;
            satl_pkg::ST_AWAIT: if (!i_sts.div_busy) n_state = satl_pkg::ST_SCAN;
            satl_pkg::ST_SCAN: begin
                if (i_sts.scan_done) begin
                    priority if (i_sts.hit) n_state = satl_pkg::ST_FIN;
                    else if (i_sts.free)    n_state = satl_pkg::ST_WRITE;
                    else                    n_state = satl_pkg::ST_LFSR;
                end
            end
            satl_pkg::ST_LFSR:  n_state = satl_pkg::ST_VDIV;
            satl_pkg::ST_VDIV:  n_state = satl_pkg::ST_VWAIT;
            satl_pkg::ST_VWAIT: if (!i_sts.div_busy) n_state = satl_pkg::ST_WRITE;
            satl_pkg::ST_WRITE: n_state = satl_pkg::ST_FIN;
            satl_pkg::ST_FIN:   n_state = satl_pkg::ST_IDLE;
            default:            n_state = satl_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            satl_pkg::ST_CLEAR: o_cmd.clr = 1'b1;
            satl_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            satl_pkg::ST_ADIV:  o_cmd.div_addr = 1'b1;
            satl_pkg::ST_AWAIT: o_cmd.take_addr = !i_sts.div_busy;
            satl_pkg::ST_SCAN:  o_cmd.scan = 1'b1;
            satl_pkg::ST_LFSR:  o_cmd.lfsr_adv = 1'b1;
            satl_pkg::ST_VDIV:  o_cmd.div_vic = 1'b1;
            satl_pkg::ST_VWAIT: o_cmd.take_vic = !i_sts.div_busy;
            satl_pkg::ST_WRITE: o_cmd.wr = 1'b1;
            satl_pkg::ST_FIN:   o_cmd.fin = 1'b1;
            default:            o_cmd = '0;
        endcase
    end

endmodule
